[sv/pfr_pkg.sv]
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared constants and controller/datapath types for the page frame
// replacement unit.
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int MAX_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 16;

    localparam int STAMP_W        = 32;
    localparam logic [STAMP_W-1:0] CNT_MAX = '1;

    localparam int FIDX_OUT_W     = 3;
    localparam int FCOUNT_W       = 4;
    localparam logic [FCOUNT_W-1:0] FCOUNT_RST = 4'd3;

    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 8;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_MODE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT  = 4'd1;

    localparam logic MODE_LRU  = 1'b0;
    localparam logic MODE_FIFO = 1'b1;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

[sv/pfr_if.sv]
// ----------------------------------------------------------------------------
// pfr_if
// Channel interfaces: page reference in, replacement result out, register
// write port.
// ----------------------------------------------------------------------------
interface pfr_access_if #(
    parameter int PAGE_BITS = pfr_pkg::PAGE_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface pfr_result_if #(
    parameter int PAGE_BITS = pfr_pkg::PAGE_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [pfr_pkg::FIDX_OUT_W-1:0] frame_index;
    logic                           evicted_valid;
    logic [PAGE_BITS-1:0]           evicted_page;
    logic [pfr_pkg::STAMP_W-1:0]    fault_total;
    logic [pfr_pkg::STAMP_W-1:0]    reference_total;

    modport source (output valid, output hit, output frame_index, output evicted_valid,
                    output evicted_page, output fault_total, output reference_total,
                    input ready);
    modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                    input evicted_page, input fault_total, input reference_total,
                    output ready);
endinterface

interface pfr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pfr_pkg::CFG_IDX_W-1:0]  index;
    logic [pfr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/page_frame_replacement_top.sv]
// ----------------------------------------------------------------------------
// page_frame_replacement_top
// LRU / FIFO page frame replacement over a fully associative frame set.
//
// Channels: access (page_number in), result (hit, frame_index, evicted_valid,
// evicted_page, fault_total, reference_total out), cfg (index, data writes:
// 0 replace_mode, 1 frame_count). A transfer happens when valid and ready
// are both high at a rising clk edge. cfg is always ready; write it only
// while no reference is in flight.
// Sequence: accept, then a scan of the N active frames (N = active frame count,
// 1..MAX_FRAMES), then commit, which loads the result register. The scan walks
// one frame per cycle through a single compare unit; a new reference is taken
// only after the previous one has committed.
// Reset (rst_n low, asynchronous): all frames empty, counters zero, LRU mode,
// frame_count 3, result channel empty.
// A stalled receiver holds the result register; the next reference is still
// accepted and scanned, and waits at commit until the result register frees.
// ----------------------------------------------------------------------------
module page_frame_replacement_top #(
    parameter int MAX_FRAMES = pfr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = pfr_pkg::PAGE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pfr_access_if.sink   access,
    pfr_result_if.source result,
    pfr_cfg_if.sink      cfg
);

    pfr_pkg::ctrl_cmd_t  cmd;
    pfr_pkg::dp_status_t status;
    logic                in_ready;

    assign access.ready = in_ready;

    pfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (access.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pfr_dpath #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .page_number (access.page_number),
        .cmd         (cmd),
        .status      (status),
        .cfg         (cfg),
        .result      (result)
    );

endmodule

[sv/pfr_ctrl.sv]
// ----------------------------------------------------------------------------
// pfr_ctrl
// Sequencer: accept a reference, scan the active frames, commit the update.
// ----------------------------------------------------------------------------
module pfr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pfr_pkg::dp_status_t status,
    output pfr_pkg::ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[sv/pfr_dpath.sv]
// ----------------------------------------------------------------------------
// pfr_dpath
// Frame table, scan registers (first match, first empty, oldest stamp),
// saturating counters, config registers and the result register.
// ----------------------------------------------------------------------------
module pfr_dpath #(
    parameter int MAX_FRAMES = pfr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = pfr_pkg::PAGE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [PAGE_BITS-1:0]  page_number,
    input  pfr_pkg::ctrl_cmd_t    cmd,
    output pfr_pkg::dp_status_t   status,
    pfr_cfg_if.sink               cfg,
    pfr_result_if.source          result
);

    localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int SW     = pfr_pkg::STAMP_W;

    logic                          mode_reg;
    logic [pfr_pkg::FCOUNT_W-1:0]  fcount_reg;

    logic [MAX_FRAMES-1:0]         valid_reg;
    logic [PAGE_BITS-1:0]          page_arr [MAX_FRAMES];
    logic [SW-1:0]                 load_arr [MAX_FRAMES];
    logic [SW-1:0]                 use_arr  [MAX_FRAMES];

    logic [SW-1:0]                 ref_cnt_reg;
    logic [SW-1:0]                 fault_cnt_reg;

    logic [PAGE_BITS-1:0]          page_reg;
    logic [FIDX_W-1:0]             scan_idx_reg;
    logic                          found_reg;
    logic [FIDX_W-1:0]             hit_idx_reg;
    logic                          empty_reg;
    logic [FIDX_W-1:0]             empty_idx_reg;
    logic [SW-1:0]                 min_stamp_reg;
    logic [FIDX_W-1:0]             victim_idx_reg;
    logic [PAGE_BITS-1:0]          victim_page_reg;

    logic                          out_valid_reg;
    logic                          out_hit_reg;
    logic [pfr_pkg::FIDX_OUT_W-1:0] out_fidx_reg;
    logic                          out_ev_valid_reg;
    logic [PAGE_BITS-1:0]          out_ev_page_reg;
    logic [SW-1:0]                 out_fault_reg;
    logic [SW-1:0]                 out_ref_reg;

    logic [4:0]                    n_eff;
    logic [FIDX_W-1:0]             last_idx;
    logic                          cur_valid;
    logic                          cur_match;
    logic [SW-1:0]                 cur_stamp;
    logic [FIDX_W-1:0]             commit_idx;
    logic [31:0]                   commit_idx_wide;
    logic                          evict;
    logic [SW-1:0]                 fault_next;
    logic [SW-1:0]                 ref_next;

    always_comb
    begin
        if (fcount_reg == '0)
            n_eff = 5'd1;
        else if (32'(fcount_reg) > MAX_FRAMES)
            n_eff = 5'(MAX_FRAMES);
        else
            n_eff = 5'(fcount_reg);
        last_idx = FIDX_W'(n_eff - 5'd1);

        cur_valid = valid_reg[scan_idx_reg];
        cur_match = cur_valid && (page_arr[scan_idx_reg] == page_reg);
        cur_stamp = (mode_reg == pfr_pkg::MODE_FIFO) ? load_arr[scan_idx_reg]
                                                     : use_arr[scan_idx_reg];

        evict = !found_reg && !empty_reg;
        if (found_reg)
            commit_idx = hit_idx_reg;
        else if (empty_reg)
            commit_idx = empty_idx_reg;
        else
            commit_idx = victim_idx_reg;
        commit_idx_wide = 32'(commit_idx);

        fault_next = fault_cnt_reg;
        if (!found_reg && (fault_cnt_reg != pfr_pkg::CNT_MAX))
            fault_next = fault_cnt_reg + 1'b1;
        ref_next = ref_cnt_reg;
        if (ref_cnt_reg != pfr_pkg::CNT_MAX)
            ref_next = ref_cnt_reg + 1'b1;

        status.scan_last = (scan_idx_reg == last_idx);
        status.out_free  = !out_valid_reg || result.ready;
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= pfr_pkg::MODE_LRU;
            fcount_reg <= pfr_pkg::FCOUNT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                pfr_pkg::REG_REPLACE_MODE: mode_reg   <= cfg.data[0];
                pfr_pkg::REG_FRAME_COUNT:  fcount_reg <= cfg.data[pfr_pkg::FCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // control state: valid bits, counters, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            ref_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (result.ready)
                out_valid_reg <= 1'b0;
            if (cmd.commit)
            begin
                valid_reg[commit_idx] <= 1'b1;
                ref_cnt_reg           <= ref_next;
                fault_cnt_reg         <= fault_next;
                out_valid_reg         <= 1'b1;
            end
        end
    end

    // frame payload and scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg     <= page_number;
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
            empty_reg    <= 1'b0;
        end
        if (cmd.scan)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (!found_reg && cur_match)
            begin
                found_reg   <= 1'b1;
                hit_idx_reg <= scan_idx_reg;
            end
            if (!empty_reg && !cur_valid)
            begin
                empty_reg     <= 1'b1;
                empty_idx_reg <= scan_idx_reg;
            end
            if ((scan_idx_reg == '0) || (cur_stamp < min_stamp_reg))
            begin
                min_stamp_reg   <= cur_stamp;
                victim_idx_reg  <= scan_idx_reg;
                victim_page_reg <= page_arr[scan_idx_reg];
            end
        end
        if (cmd.commit)
        begin
            use_arr[commit_idx] <= ref_cnt_reg;
            if (!found_reg)
            begin
                page_arr[commit_idx] <= page_reg;
                load_arr[commit_idx] <= ref_cnt_reg;
            end
            out_hit_reg      <= found_reg;
            out_fidx_reg     <= commit_idx_wide[pfr_pkg::FIDX_OUT_W-1:0];
            out_ev_valid_reg <= evict;
            out_ev_page_reg  <= evict ? victim_page_reg : '0;
            out_fault_reg    <= fault_next;
            out_ref_reg      <= ref_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.hit             = out_hit_reg;
    assign result.frame_index     = out_fidx_reg;
    assign result.evicted_valid   = out_ev_valid_reg;
    assign result.evicted_page    = out_ev_page_reg;
    assign result.fault_total     = out_fault_reg;
    assign result.reference_total = out_ref_reg;

endmodule
